>>> design/hlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hlp_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int          KEY_W        = 64;
  localparam int          VAL_W        = 64;
  localparam int          CNT_W        = 10;
  localparam int          MIX_SHIFT    = 33;

  localparam logic [63:0]      MIX_C1          = 64'hff51afd7ed558ccd;
  localparam logic [63:0]      MIX_C2          = 64'hc4ceb9fe1a85ec53;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 10'd512;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_NEXT = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_END       = 3'd5
  } status_t;

  // one table slot: used flag, key, value
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

>>> design/hlp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hlp_in_if #(parameter int SLOT_W = 11);
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [63:0]       key;
  logic [63:0]       value;
  logic [SLOT_W-1:0] start_slot;
  modport source (output valid, command, key, value, start_slot, input ready);
  modport sink   (input valid, command, key, value, start_slot, output ready);
endinterface

interface hlp_out_if #(parameter int SLOT_W = 11);
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [63:0]       value_out;
  logic [63:0]       key_out;
  logic [SLOT_W-1:0] slot_out;
  logic [9:0]        entry_count;
  modport source (output valid, status, value_out, key_out, slot_out, entry_count,
                  input ready);
  modport sink   (input valid, status, value_out, key_out, slot_out, entry_count,
                  output ready);
endinterface

interface hlp_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] max_entries;
  modport source (output valid, max_entries, input ready);
  modport sink   (input valid, max_entries, output ready);
endinterface
`default_nettype wire

>>> design/hlp_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// 64-bit finalizer on one shared 32x32 multiplier; done is registered and hash is ready when it rises.
module hlp_mix (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] key,
  output logic             done,
  output logic [63:0]      hash
);
  import hlp_pkg::*;

  logic [63:0] x_r, x_nxt, acc_r, acc_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0] op_a, op_b;
  logic [63:0] cst, prod, term;

  // phases 0-2: first multiply, 3: xor-shift, 4-6: second multiply, 7: xor-shift
  always_comb begin
    cst = ph_r[2] ? MIX_C2 : MIX_C1;
    case (ph_r[1:0])
      2'd0: begin
        op_a = x_r[31:0];
        op_b = cst[31:0];
      end
      2'd1: begin
        op_a = x_r[31:0];
        op_b = cst[63:32];
      end
      default: begin
        op_a = x_r[63:32];
        op_b = cst[31:0];
      end
    endcase
    prod = {32'd0, op_a} * {32'd0, op_b};
    term = (ph_r[1:0] == 2'd0) ? prod : {prod[31:0], 32'd0};
  end

  always_comb begin
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = key ^ (key >> MIX_SHIFT);
      acc_nxt  = '0;
      ph_nxt   = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ph_r == 3'd3) begin
        x_nxt   = acc_r ^ (acc_r >> MIX_SHIFT);
        acc_nxt = '0;
        ph_nxt  = ph_r + 3'd1;
      end else if (ph_r == 3'd7) begin
        x_nxt    = acc_r ^ (acc_r >> MIX_SHIFT);
        ph_nxt   = 3'd0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = acc_r + term;
        ph_nxt  = ph_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      ph_r   <= 3'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign hash = x_r;

  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mix done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && ph_r == 3'd0) else $error("mix start not taken");
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ph_r == 3'd0) else $error("mix phase moved while idle");

endmodule
`default_nettype wire

>>> design/hash_table_linear_probe_core.sv
// Hash table, 64-bit keys and values, open addressing with linear probing over
// CAPACITY slots (power of two). One command word in, one result word out.
// After reset the block clears the used flags of all CAPACITY slots and
// accepts no command word meanwhile (cfg writes are taken at any time).
// Steps per command: load the command word, hash the key on the shared 32x32
// multiplier for put/get (start pulse, 8 multiply/xor-shift phases, done), then
// per probed slot a registered table read and a compare, then hand out the
// result word, held until taken. Next-occupied skips the hashing and scans slot
// by slot with the same read and compare. One command at a time.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_linear_probe_core #(
  parameter int unsigned CAPACITY = hlp_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hlp_in_if.sink    in_ch,
  hlp_out_if.source out_ch,
  hlp_cfg_if.sink   cfg_ch
);
  import hlp_pkg::*;

  localparam int AW     = $clog2(CAPACITY);
  localparam int SLOT_W = AW + 1;
  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(CAPACITY);
  localparam logic [AW-1:0]     LAST     = AW'(CAPACITY - 1);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_HASH = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // latched command word
  cmd_t              cmd_r, cmd_nxt;
  logic [63:0]       key_r, key_nxt, val_r, val_nxt;

  // probe / scan position and probe count
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     n_r, n_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, max_r, max_nxt;

  // result word
  status_t           status_r, status_nxt;
  logic [63:0]       vout_r, vout_nxt, kout_r, kout_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // table memory
  entry_t            mem [CAPACITY];
  entry_t            rd_q, wdata;
  logic              we;

  logic              hash_go_r;
  logic              mix_done;
  logic [63:0]       mix_hash;
  logic              in_acc;

  hlp_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_go_r),
    .key   (key_r),
    .done  (mix_done),
    .hash  (mix_hash)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r] <= wdata;
    end
    rd_q <= mem[addr_r];
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    addr_nxt   = addr_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    max_nxt    = max_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    kout_nxt   = kout_r;
    slot_nxt   = slot_r;
    we         = 1'b0;
    wdata      = '0;

    if (cfg_ch.valid) begin
      max_nxt = cfg_ch.max_entries;
    end

    case (state_r)
      S_CLR: begin
        // clearing pass: one slot per cycle
        we       = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = cmd_t'(in_ch.command);
          key_nxt  = in_ch.key;
          val_nxt  = in_ch.value;
          vout_nxt = '0;
          kout_nxt = '0;
          case (cmd_t'(in_ch.command))
            CMD_PUT, CMD_GET: begin
              state_nxt = S_HASH;
            end
            CMD_NEXT: begin
              if (in_ch.start_slot[AW]) begin
                status_nxt = ST_END;
                slot_nxt   = SLOT_END;
                state_nxt  = S_RESP;
              end else begin
                addr_nxt  = in_ch.start_slot[AW-1:0];
                state_nxt = S_RD;
              end
            end
            default: begin
              status_nxt = ST_NOT_FOUND;
              slot_nxt   = '0;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end
      S_HASH: begin
        // kick the mixer on entry, wait for its done pulse
        if (mix_done) begin
          addr_nxt  = mix_hash[AW-1:0];
          n_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == CMD_NEXT) begin
          if (rd_q.used) begin
            status_nxt = ST_FOUND;
            slot_nxt   = {1'b0, addr_r};
            vout_nxt   = rd_q.value;
            kout_nxt   = rd_q.key;
            state_nxt  = S_RESP;
          end else if (addr_r == LAST) begin
            status_nxt = ST_END;
            slot_nxt   = SLOT_END;
            state_nxt  = S_RESP;
          end else begin
            addr_nxt  = addr_r + AW'(1);
            state_nxt = S_RD;
          end
        end else if (!rd_q.used) begin
          // empty slot ends the probe
          slot_nxt  = {1'b0, addr_r};
          state_nxt = S_RESP;
          if (cmd_r == CMD_GET) begin
            status_nxt = ST_NOT_FOUND;
          end else if (cnt_r >= max_r) begin
            status_nxt = ST_FULL;
          end else begin
            we         = 1'b1;
            wdata      = '{used: 1'b1, key: key_r, value: val_r};
            cnt_nxt    = cnt_r + CNT_W'(1);
            status_nxt = ST_INSERTED;
          end
        end else if (rd_q.key == key_r) begin
          slot_nxt  = {1'b0, addr_r};
          state_nxt = S_RESP;
          if (cmd_r == CMD_GET) begin
            status_nxt = ST_FOUND;
            vout_nxt   = rd_q.value;
          end else begin
            we         = 1'b1;
            wdata      = '{used: 1'b1, key: key_r, value: val_r};
            status_nxt = ST_UPDATED;
          end
        end else if (n_r == LAST) begin
          // wrapped all the way round
          slot_nxt   = SLOT_END;
          status_nxt = (cmd_r == CMD_GET) ? ST_NOT_FOUND : ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          n_nxt     = n_r + AW'(1);
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // one-cycle start pulse on first cycle of S_HASH, key_r is loaded by then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_go_r <= 1'b0;
    end else begin
      hash_go_r <= (state_r == S_IDLE) && (state_nxt == S_HASH);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    n_r    <= n_nxt;
    vout_r <= vout_nxt;
    kout_r <= kout_nxt;
    slot_r <= slot_nxt;
    if (!rst_n) begin
      state_r  <= S_CLR;
      addr_r   <= '0;
      cnt_r    <= '0;
      max_r    <= MAX_ENTRIES_RST;
      status_r <= ST_NOT_FOUND;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      max_r    <= max_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid       = (state_r == S_RESP);
  assign out_ch.status      = status_r;
  assign out_ch.value_out   = vout_r;
  assign out_ch.key_out     = kout_r;
  assign out_ch.slot_out    = slot_r;
  assign out_ch.entry_count = cnt_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("accepting while result pending");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1))))
    else $error("entry count moved by more than one");
  a_mix_done: assert property (@(posedge clk) disable iff (!rst_n)
    mix_done |-> state_r == S_HASH) else $error("hash result outside hash phase");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLR || state_r == S_CHK)) else $error("stray table write");

endmodule
`default_nettype wire
